FILE: sv/gwd_pkg.sv
package gwd_pkg;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 9;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned CENT_W  = 8;
  localparam int unsigned YY_W    = 7;
  localparam int unsigned YTERM_W = 8;
  localparam int unsigned SUM_W   = 11;
  localparam int unsigned QUOT_W  = 9;

  localparam logic [CMD_W-1:0] CMD_MONTH_DAY = 1'b0;
  localparam logic [CMD_W-1:0] CMD_YEAR_DAY  = 1'b1;

  // floor(y / 100) == (y * RECIP_100) >> RECIP_100_SH for y < 2**YEAR_W
  localparam int unsigned RECIP_100_W  = 13;
  localparam logic [RECIP_100_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_100_SH = 19;

  // floor(s / 7) == (s * RECIP_7) >> RECIP_7_SH for s < 2**SUM_W
  localparam int unsigned RECIP_7_W  = 12;
  localparam logic [RECIP_7_W-1:0] RECIP_7 = 12'd2341;
  localparam int unsigned RECIP_7_SH = 14;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] FEB_END_DAY  = 9'd59;
  localparam logic [DAY_W-1:0] JAN_END_DAY  = 9'd31;
  localparam logic [DAY_W-1:0] NOV_END_DAY  = 9'd334;

  localparam logic [DAY_W-1:0] CUM_DAYS [12] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_value;
  } gwd_req_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_value;
    logic               leap;
    logic [YTERM_W-1:0] yterm;
  } gwd_yinfo_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [SUM_W-1:0]   sum;
  } gwd_sum_t;

endpackage

FILE: sv/gwd_in_if.sv
interface gwd_in_if import gwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_value;

  modport source (output valid, cmd, year, month, day_value, input ready);
  modport sink (input valid, cmd, year, month, day_value, output ready);
endinterface

FILE: sv/gwd_out_if.sv
interface gwd_out_if import gwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WDAY_W-1:0]  weekday;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_of_month;

  modport source (output valid, weekday, month_out, day_of_month, input ready);
  modport sink (input valid, weekday, month_out, day_of_month, output ready);
endinterface

FILE: sv/gregorian_weekday_calc.sv
// channel  dir  payload                                 transaction
// in_i     in   cmd, year, month, day_value             valid && ready
// out_o    out  weekday, month_out, day_of_month        valid && ready
//
// Six register stages: century split, year terms, month map, sum, mod-7
// quotient, remainder. One transaction per cycle while out_o is not stalled.
// Reset clears the stage valid bits only.
// All stages advance together; in_i.ready drops only while the output
// holds a result that out_o does not take, and then every stage holds.
module gregorian_weekday_calc import gwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gwd_in_if.sink    in_i,
  gwd_out_if.source out_o
);

  logic       en;
  gwd_req_t   req;
  logic       ysp_valid;
  gwd_yinfo_t yinfo;
  logic       sum_valid;
  gwd_sum_t   sum;

  assign en         = !(out_o.valid && !out_o.ready);
  assign in_i.ready = en;

  assign req.cmd       = in_i.cmd;
  assign req.year      = in_i.year;
  assign req.month     = in_i.month;
  assign req.day_value = in_i.day_value;

  gwd_year_split u_year_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .req_i   (req),
    .valid_o (ysp_valid),
    .yinfo_o (yinfo)
  );

  gwd_date_map u_date_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ysp_valid),
    .yinfo_i (yinfo),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  gwd_mod7 u_mod7 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (sum_valid),
    .sum_i     (sum),
    .valid_o   (out_o.valid),
    .weekday_o (out_o.weekday),
    .month_o   (out_o.month_out),
    .day_o     (out_o.day_of_month)
  );

`ifndef SYNTHESIS
  a_wday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.weekday <= 3'd6))
    else $error("weekday out of range");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken during output stall");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sum_valid) && $stable(ysp_valid)))
    else $error("pipeline moved during stall");

  a_sum_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid && en) ##1 en |=> out_o.valid)
    else $error("transaction lost in mod-7 stages");
`endif

endmodule

FILE: sv/gwd_year_split.sv
module gwd_year_split import gwd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  gwd_req_t   req_i,
  output logic       valid_o,
  output gwd_yinfo_t yinfo_o
);

  logic                               s1_valid_q;
  gwd_req_t                           s1_req_q;
  logic [CENT_W-1:0]                  s1_cent_q, s1_cent_d;
  logic [YEAR_W+RECIP_100_W-1:0]      cent_prod;
  logic                               s2_valid_q;
  gwd_yinfo_t                         s2_yinfo_q, s2_yinfo_d;
  logic [YEAR_W-1:0]                  hundreds;
  logic [YY_W-1:0]                    yy;
  logic [1:0]                         cent_mod;
  logic [1:0]                         cent_code;

  assign cent_prod = (YEAR_W+RECIP_100_W)'(req_i.year) * (YEAR_W+RECIP_100_W)'(RECIP_100);
  assign s1_cent_d = cent_prod[RECIP_100_SH +: CENT_W];

  always_comb begin
    hundreds  = YEAR_W'(s1_cent_q) * YEAR_W'(100);
    yy        = YY_W'(s1_req_q.year - hundreds);
    cent_mod  = s1_cent_q[1:0];
    cent_code = 2'd3 - cent_mod;
    s2_yinfo_d.cmd       = s1_req_q.cmd;
    s2_yinfo_d.month     = s1_req_q.month;
    s2_yinfo_d.day_value = s1_req_q.day_value;
    s2_yinfo_d.leap      = ((s1_req_q.year[1:0] == 2'd0) && (yy != '0)) ||
                           ((yy == '0) && (cent_mod == 2'd0));
    s2_yinfo_d.yterm     = YTERM_W'(yy) + YTERM_W'(yy[YY_W-1:2]) +
                           YTERM_W'({cent_code, 1'b0}) + YTERM_W'(7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_req_q   <= req_i;
      s1_cent_q  <= s1_cent_d;
      s2_yinfo_q <= s2_yinfo_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign yinfo_o = s2_yinfo_q;

endmodule

FILE: sv/gwd_date_map.sv
module gwd_date_map import gwd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  gwd_yinfo_t yinfo_i,
  output logic       valid_o,
  output gwd_sum_t   sum_o
);

  logic               s3_valid_q;
  logic [MONTH_W-1:0] s3_month_q, s3_month_d;
  logic [DAY_W-1:0]   s3_day_q, s3_day_d;
  logic               s3_leap_q;
  logic [YTERM_W-1:0] s3_yterm_q;
  logic               s4_valid_q;
  gwd_sum_t           s4_sum_q, s4_sum_d;
  logic [DAY_W-1:0]   look;
  logic [MONTH_W-1:0] conv_month;
  logic [DAY_W-1:0]   prior_days;
  logic               leap_fix;

  // day of year to month and day of month; for CMD_MONTH_DAY month and day pass through
  always_comb begin
    look = yinfo_i.day_value -
           DAY_W'(yinfo_i.leap && (yinfo_i.day_value > FEB_END_DAY));
    conv_month = MONTH_DEC;
    for (int i = 11; i >= 1; i--) begin
      if (CUM_DAYS[4'(i)] >= look) begin
        conv_month = MONTH_W'(i + 1);
      end
    end
    if (look <= JAN_END_DAY) begin
      conv_month = MONTH_JAN;
    end else if (look > NOV_END_DAY) begin
      conv_month = MONTH_DEC;
    end
    if (yinfo_i.cmd == CMD_MONTH_DAY) begin
      s3_month_d = yinfo_i.month;
      s3_day_d   = yinfo_i.day_value;
    end else if (conv_month == MONTH_JAN) begin
      s3_month_d = conv_month;
      s3_day_d   = yinfo_i.day_value;
    end else begin
      s3_month_d = conv_month;
      s3_day_d   = yinfo_i.day_value - CUM_DAYS[MONTH_W'(conv_month - MONTH_FEB)] -
                   DAY_W'(yinfo_i.leap && (conv_month > MONTH_FEB));
    end
  end

  // weekday sum before reduction
  always_comb begin
    if (s3_month_q <= MONTH_JAN) begin
      prior_days = '0;
    end else if (s3_month_q > MONTH_DEC) begin
      prior_days = CUM_DAYS[11];
    end else begin
      prior_days = CUM_DAYS[MONTH_W'(s3_month_q - MONTH_FEB)];
    end
    leap_fix = s3_leap_q && (s3_month_q <= MONTH_FEB);
    s4_sum_d.month = s3_month_q;
    s4_sum_d.day   = s3_day_q;
    s4_sum_d.sum   = SUM_W'(s3_day_q) + SUM_W'(prior_days) + SUM_W'(s3_yterm_q) -
                     SUM_W'(leap_fix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_month_q <= s3_month_d;
      s3_day_q   <= s3_day_d;
      s3_leap_q  <= yinfo_i.leap;
      s3_yterm_q <= yinfo_i.yterm;
      s4_sum_q   <= s4_sum_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign sum_o   = s4_sum_q;

endmodule

FILE: sv/gwd_mod7.sv
module gwd_mod7 import gwd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  gwd_sum_t           sum_i,
  output logic               valid_o,
  output logic [WDAY_W-1:0]  weekday_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [DAY_W-1:0]   day_o
);

  logic [SUM_W+RECIP_7_W-1:0] quot_prod;
  logic                       s5_valid_q;
  gwd_sum_t                   s5_sum_q;
  logic [QUOT_W-1:0]          s5_quot_q, s5_quot_d;
  logic [SUM_W-1:0]           rem;
  logic                       s6_valid_q;
  logic [WDAY_W-1:0]          s6_wday_q, s6_wday_d;
  logic [MONTH_W-1:0]         s6_month_q;
  logic [DAY_W-1:0]           s6_day_q;

  assign quot_prod = (SUM_W+RECIP_7_W)'(sum_i.sum) * (SUM_W+RECIP_7_W)'(RECIP_7);
  assign s5_quot_d = quot_prod[RECIP_7_SH +: QUOT_W];
  assign rem       = s5_sum_q.sum - SUM_W'(s5_quot_q) * SUM_W'(7);
  assign s6_wday_d = WDAY_W'(rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (en_i) begin
      s5_valid_q <= valid_i;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_sum_q   <= sum_i;
      s5_quot_q  <= s5_quot_d;
      s6_wday_q  <= s6_wday_d;
      s6_month_q <= s5_sum_q.month;
      s6_day_q   <= s5_sum_q.day;
    end
  end

  assign valid_o   = s6_valid_q;
  assign weekday_o = s6_wday_q;
  assign month_o   = s6_month_q;
  assign day_o     = s6_day_q;

endmodule
